FILE: hw/rtl/bhdi_pkg.sv
package bhdi_pkg;

  localparam int DISP_W    = 24;
  localparam int RATIO_F   = 16;
  localparam int RATIO_W   = RATIO_F + 1;
  localparam int TRIG_W    = 16;
  localparam int TRIG_F    = 14;
  localparam int TRIG_ONE  = 1 << TRIG_F;

  // local-axis displacement, signed, range -2^(DISP_W+1) to 2^(DISP_W+1)-1
  localparam int LOC_W     = DISP_W + 2;
  localparam int ROT_PR_W  = DISP_W + TRIG_W;
  localparam int ROT_SUM_W = ROT_PR_W + 2;

  localparam int SQ_W      = 2 * RATIO_W;
  localparam int SHAPE_W   = RATIO_F + 3;

  localparam int PROD_W    = SHAPE_W + LOC_W;
  localparam int PSUM_W    = PROD_W + 3;
  localparam int VL_W      = PSUM_W - RATIO_F;

  localparam int GP_W      = VL_W + TRIG_W;
  localparam int GSUM_W    = GP_W + 2;

  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [DISP_W-1:0]  disp_t;
  typedef logic        [RATIO_W-1:0] ratio_t;
  typedef logic signed [LOC_W-1:0]   loc_t;
  typedef logic signed [SHAPE_W-1:0] shape_t;
  typedef logic signed [VL_W-1:0]    vl_t;

  localparam ratio_t RATIO_ONE = ratio_t'(1 << RATIO_F);
  localparam trig_t  TRIG_MAX  = trig_t'(TRIG_ONE);
  localparam trig_t  TRIG_MIN  = trig_t'(-TRIG_ONE);

  typedef struct packed {
    ratio_t s;
    shape_t n1;
    shape_t n2;
    shape_t n3;
    shape_t n4;
  } shape_set_t;

  typedef struct packed {
    loc_t u1;
    loc_t v1;
    loc_t u2;
    loc_t v2;
  } local_set_t;

  typedef struct packed {
    trig_t c;
    trig_t m;
    disp_t r1;
    disp_t r2;
  } side_t;

endpackage

FILE: hw/rtl/beam_hermite_displacement_interp.sv
// Pipeline: a beat taken at a clock edge goes through the input register, 4 rotate/shape
// stages and 4 interpolate/rotate-back stages, then shows on the out_ ports with out_valid.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// The receiver cannot stall; out_valid marks each result for exactly one cycle.
// Reset (rst_n low, synchronous) clears the valid bits; data in flight is dropped.
module beam_hermite_displacement_interp
  import bhdi_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  trig_t  in_dir_cos,
  input  trig_t  in_dir_sin,
  input  disp_t  in_start_disp_x,
  input  disp_t  in_start_disp_y,
  input  disp_t  in_start_rotation,
  input  disp_t  in_end_disp_x,
  input  disp_t  in_end_disp_y,
  input  disp_t  in_end_rotation,
  input  ratio_t in_position_ratio,
  output logic   out_valid,
  output disp_t  out_interp_disp_x,
  output disp_t  out_interp_disp_y
);

  localparam int VLD_LEN = 9;

  logic [VLD_LEN-1:0] vld_r, vld_nxt;
  logic               accept;

  trig_t  c_r, m_r, c_nxt, m_nxt;
  disp_t  x1_r, y1_r, x2_r, y2_r;
  disp_t  r1_r, r2_r;
  ratio_t s_r, s_nxt;
  side_t  side0;
  side_t  side_d_r [4];

  loc_t       u1, v1, u2, v2;
  local_set_t loc_now;
  local_set_t loc_d_r [2];
  shape_set_t shape;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    c_nxt = in_dir_cos;
    if (in_dir_cos > TRIG_MAX) begin
      c_nxt = TRIG_MAX;
    end else if (in_dir_cos < TRIG_MIN) begin
      c_nxt = TRIG_MIN;
    end
    m_nxt = in_dir_sin;
    if (in_dir_sin > TRIG_MAX) begin
      m_nxt = TRIG_MAX;
    end else if (in_dir_sin < TRIG_MIN) begin
      m_nxt = TRIG_MIN;
    end
    s_nxt = (in_position_ratio > RATIO_ONE) ? RATIO_ONE : in_position_ratio;
  end

  assign vld_nxt = {vld_r[VLD_LEN-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // take the beat into the input register, with cos, sin and ratio clamped
  always_ff @(posedge clk) begin
    c_r  <= c_nxt;
    m_r  <= m_nxt;
    s_r  <= s_nxt;
    x1_r <= in_start_disp_x;
    y1_r <= in_start_disp_y;
    x2_r <= in_end_disp_x;
    y2_r <= in_end_disp_y;
    r1_r <= in_start_rotation;
    r2_r <= in_end_rotation;
  end

  assign side0 = '{c: c_r, m: m_r, r1: r1_r, r2: r2_r};

  bhdi_to_local u_local_start (
    .clk (clk),
    .c   (c_r),
    .m   (m_r),
    .x   (x1_r),
    .y   (y1_r),
    .u   (u1),
    .v   (v1)
  );

  bhdi_to_local u_local_end (
    .clk (clk),
    .c   (c_r),
    .m   (m_r),
    .x   (x2_r),
    .y   (y2_r),
    .u   (u2),
    .v   (v2)
  );

  bhdi_shape u_shape (
    .clk   (clk),
    .s     (s_r),
    .shape (shape)
  );

  assign loc_now = '{u1: u1, v1: v1, u2: u2, v2: v2};

  // hold rotation/trig and local values until the shape functions are ready
  always_ff @(posedge clk) begin
    side_d_r[0] <= side0;
    for (int i = 1; i < 4; i++) begin
      side_d_r[i] <= side_d_r[i-1];
    end
    loc_d_r[0] <= loc_now;
    loc_d_r[1] <= loc_d_r[0];
  end

  bhdi_interp u_interp (
    .clk   (clk),
    .loc   (loc_d_r[1]),
    .side  (side_d_r[3]),
    .shape (shape),
    .gx    (out_interp_disp_x),
    .gy    (out_interp_disp_y)
  );

  assign out_valid = vld_r[VLD_LEN-1];

endmodule

FILE: hw/rtl/bhdi_to_local.sv
module bhdi_to_local
  import bhdi_pkg::*;
(
  input  logic  clk,
  input  trig_t c,
  input  trig_t m,
  input  disp_t x,
  input  disp_t y,
  output loc_t  u,
  output loc_t  v
);

  localparam logic signed [ROT_SUM_W-1:0] ROT_HALF = ROT_SUM_W'(1 << (TRIG_F - 1));

  logic signed [ROT_PR_W-1:0]  xc_r, ym_r, xm_r, yc_r;
  logic signed [ROT_PR_W-1:0]  xc_nxt, ym_nxt, xm_nxt, yc_nxt;
  logic signed [ROT_SUM_W-1:0] u_sum, v_sum;
  loc_t                        u_r, v_r, u_nxt, v_nxt;

  assign xc_nxt = x * c;
  assign ym_nxt = y * m;
  assign xm_nxt = x * m;
  assign yc_nxt = y * c;

  always_comb begin
    u_sum = ROT_SUM_W'(xc_r) + ROT_SUM_W'(ym_r) + ROT_HALF;
    v_sum = ROT_SUM_W'(yc_r) - ROT_SUM_W'(xm_r) + ROT_HALF;
    u_nxt = loc_t'(u_sum >>> TRIG_F);
    v_nxt = loc_t'(v_sum >>> TRIG_F);
  end

  always_ff @(posedge clk) begin
    xc_r <= xc_nxt;
    ym_r <= ym_nxt;
    xm_r <= xm_nxt;
    yc_r <= yc_nxt;
    u_r  <= u_nxt;
    v_r  <= v_nxt;
  end

  assign u = u_r;
  assign v = v_r;

endmodule

FILE: hw/rtl/bhdi_shape.sv
module bhdi_shape
  import bhdi_pkg::*;
(
  input  logic       clk,
  input  ratio_t     s,
  output shape_set_t shape
);

  localparam logic [SQ_W-1:0] SQ_HALF   = SQ_W'(1 << (RATIO_F - 1));
  localparam shape_t          SHAPE_ONE = SHAPE_W'(RATIO_ONE);

  logic [SQ_W-1:0] ss_r, ss_nxt, s3p_r, s3p_nxt;
  ratio_t          s_d1_r, s_d2_r, s_d3_r;
  ratio_t          s2_r, s2_nxt, s2_d3_r, s3_nxt;
  shape_t          s2e, s3e, se;
  shape_set_t      shape_r, shape_nxt;

  assign ss_nxt  = SQ_W'(s) * SQ_W'(s);
  assign s2_nxt  = ratio_t'((ss_r + SQ_HALF) >> RATIO_F);
  assign s3p_nxt = SQ_W'(s2_r) * SQ_W'(s_d2_r);
  assign s3_nxt  = ratio_t'((s3p_r + SQ_HALF) >> RATIO_F);

  always_comb begin
    se  = shape_t'(s_d3_r);
    s2e = shape_t'(s2_d3_r);
    s3e = shape_t'(s3_nxt);
    shape_nxt.s  = s_d3_r;
    shape_nxt.n1 = SHAPE_ONE - s2e - (s2e <<< 1) + (s3e <<< 1);
    shape_nxt.n2 = se - (s2e <<< 1) + s3e;
    shape_nxt.n3 = s2e + (s2e <<< 1) - (s3e <<< 1);
    shape_nxt.n4 = s3e - s2e;
  end

  // s*s, round, s2*s, round + combine
  always_ff @(posedge clk) begin
    ss_r    <= ss_nxt;
    s_d1_r  <= s;
    s2_r    <= s2_nxt;
    s_d2_r  <= s_d1_r;
    s3p_r   <= s3p_nxt;
    s2_d3_r <= s2_r;
    s_d3_r  <= s_d2_r;
    shape_r <= shape_nxt;
  end

  assign shape = shape_r;

endmodule

FILE: hw/rtl/bhdi_interp.sv
module bhdi_interp
  import bhdi_pkg::*;
(
  input  logic       clk,
  input  local_set_t loc,
  input  side_t      side,
  input  shape_set_t shape,
  output disp_t      gx,
  output disp_t      gy
);

  localparam logic signed [PSUM_W-1:0] P_HALF = PSUM_W'(1 << (RATIO_F - 1));
  localparam logic signed [GSUM_W-1:0] G_HALF = GSUM_W'(1 << (TRIG_F - 1));
  localparam logic signed [GSUM_W-1:0] D_MAX  = GSUM_W'((1 << (DISP_W - 1)) - 1);
  localparam logic signed [GSUM_W-1:0] D_MIN  = GSUM_W'(-(1 << (DISP_W - 1)));

  function automatic disp_t sat_disp(input logic signed [GSUM_W-1:0] val);
    disp_t res;
    if (val > D_MAX) begin
      res = disp_t'(D_MAX);
    end else if (val < D_MIN) begin
      res = disp_t'(D_MIN);
    end else begin
      res = disp_t'(val);
    end
    return res;
  endfunction

  shape_t                   one_m_s, s_e;
  loc_t                     r1e, r2e;
  logic signed [PROD_W-1:0] pu1_r, pu2_r, q1_r, q2_r, q3_r, q4_r;
  logic signed [PROD_W-1:0] pu1_nxt, pu2_nxt, q1_nxt, q2_nxt, q3_nxt, q4_nxt;
  logic signed [PSUM_W-1:0] ul_sum, vl_sum;
  loc_t                     ul_r, ul_nxt;
  vl_t                      vl_r, vl_nxt;
  trig_t                    c_d_r [2];
  trig_t                    m_d_r [2];
  logic signed [GP_W-1:0]   pc_r, pm_r, qm_r, qc_r;
  logic signed [GP_W-1:0]   pc_nxt, pm_nxt, qm_nxt, qc_nxt;
  logic signed [GSUM_W-1:0] gx_sum, gy_sum;
  disp_t                    gx_r, gy_r, gx_nxt, gy_nxt;

  always_comb begin
    s_e     = shape_t'(shape.s);
    one_m_s = shape_t'(RATIO_ONE) - s_e;
    r1e     = loc_t'(side.r1);
    r2e     = loc_t'(side.r2);
    pu1_nxt = one_m_s * loc.u1;
    pu2_nxt = s_e * loc.u2;
    q1_nxt  = shape.n1 * loc.v1;
    q2_nxt  = shape.n2 * r1e;
    q3_nxt  = shape.n3 * loc.v2;
    q4_nxt  = shape.n4 * r2e;
  end

  always_comb begin
    ul_sum = PSUM_W'(pu1_r) + PSUM_W'(pu2_r) + P_HALF;
    vl_sum = PSUM_W'(q1_r) + PSUM_W'(q2_r) + PSUM_W'(q3_r) + PSUM_W'(q4_r) + P_HALF;
    ul_nxt = loc_t'(ul_sum >>> RATIO_F);
    vl_nxt = vl_t'(vl_sum >>> RATIO_F);
  end

  always_comb begin
    pc_nxt = GP_W'(ul_r) * GP_W'(c_d_r[1]);
    pm_nxt = GP_W'(ul_r) * GP_W'(m_d_r[1]);
    qm_nxt = GP_W'(vl_r) * GP_W'(m_d_r[1]);
    qc_nxt = GP_W'(vl_r) * GP_W'(c_d_r[1]);
  end

  always_comb begin
    gx_sum = GSUM_W'(pc_r) - GSUM_W'(qm_r) + G_HALF;
    gy_sum = GSUM_W'(pm_r) + GSUM_W'(qc_r) + G_HALF;
    gx_nxt = sat_disp(gx_sum >>> TRIG_F);
    gy_nxt = sat_disp(gy_sum >>> TRIG_F);
  end

  always_ff @(posedge clk) begin
    pu1_r    <= pu1_nxt;
    pu2_r    <= pu2_nxt;
    q1_r     <= q1_nxt;
    q2_r     <= q2_nxt;
    q3_r     <= q3_nxt;
    q4_r     <= q4_nxt;
    c_d_r[0] <= side.c;
    m_d_r[0] <= side.m;
    c_d_r[1] <= c_d_r[0];
    m_d_r[1] <= m_d_r[0];
    ul_r     <= ul_nxt;
    vl_r     <= vl_nxt;
    pc_r     <= pc_nxt;
    pm_r     <= pm_nxt;
    qm_r     <= qm_nxt;
    qc_r     <= qc_nxt;
    gx_r     <= gx_nxt;
    gy_r     <= gy_nxt;
  end

  assign gx = gx_r;
  assign gy = gy_r;

endmodule
